// ----- rtl/rrbi_pkg.sv -----
// shared widths, limits and datapath types for the row bump insert block
package rrbi_pkg;

   localparam int CNT_W          = 32;
   localparam int LEN_W          = 16;
   localparam int OUT_VAL_W      = 16;
   localparam int MAX_OUT        = 32;
   localparam int KW             = $clog2(MAX_OUT + 1);
   localparam int MAX_RUNS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] b;
   } alu_in_type;

   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic [CNT_W-1:0] diff;
      logic             ge;
   } alu_out_type;

endpackage

// ----- rtl/rle_row_bump_insert.sv -----
// Row insertion on a sorted run-length row, with bumped runs sent out in order.
// The row lives in a run memory with one read and one write port, and every phase walks
// it one run per cycle (the emit pass only while the result side does not stall) under a
// small sequencer with one shared count unit: a scan up to the insert point, a right shift
// to open a slot, a measure pass over the runs to bump, an emit pass with one result per
// bumped run, and a left compaction of the tail. req_stall stays high from the input
// transfer of an item until the sequencer is back in idle. The last result sits in the
// output register while the next item is already taken.
module rle_row_bump_insert #(
   parameter int MAX_RUNS   = rrbi_pkg::MAX_RUNS_DEF,
   parameter int VALUE_BITS = rrbi_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rrbi_pkg::OUT_VAL_W-1:0]  req_run_value,
   input  logic [rrbi_pkg::LEN_W-1:0]      req_run_length,
   input  logic                            req_batch_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrbi_pkg::OUT_VAL_W-1:0]  rsp_bump_value,
   output logic [rrbi_pkg::CNT_W-1:0]      rsp_bump_length,
   output logic [rrbi_pkg::CNT_W-1:0]      rsp_bump_offset,
   output logic                            rsp_no_bump,
   output logic                            rsp_last,
   output logic                            rsp_batch_end_out,
   output logic                            rsp_overflow,
   output logic [rrbi_pkg::CNT_W-1:0]      rsp_row_cells
);

   localparam int IW    = $clog2(MAX_RUNS);
   localparam int DEPTH = 1 << IW;
   localparam int PW    = $clog2(MAX_RUNS + 1);
   localparam int VB    = VALUE_BITS;
   localparam int CW    = rrbi_pkg::CNT_W;
   localparam int LW    = rrbi_pkg::LEN_W;
   localparam int OW    = rrbi_pkg::OUT_VAL_W;
   localparam int KW    = rrbi_pkg::KW;
   localparam int TOT_W = CW + PW;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_PLACE = 9'b000000100,
      S_SHR   = 9'b000001000,
      S_INS   = 9'b000010000,
      S_MEAS  = 9'b000100000,
      S_EMIT  = 9'b001000000,
      S_COMP  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   // run memory
   logic [VB-1:0] val_mem [DEPTH];
   logic [CW-1:0] cnt_mem [DEPTH];
   logic [VB-1:0] rd_val_ff;
   logic [CW-1:0] rd_cnt_ff;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [VB-1:0] wr_val;
   logic [CW-1:0] wr_cnt;
   logic [IW-1:0] rd_addr;

   // control
   state_type      state_ff, state_in;
   logic [PW-1:0]  used_ff, used_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [CW-1:0]  batch_ff, batch_in;
   logic [PW-1:0]  ptr_ff, ptr_in;

   // per-item working registers
   logic [VB-1:0]  v_ff, v_in;
   logic [LW-1:0]  n_ff, n_in;
   logic           be_ff, be_in;
   logic           ovf_ff, ovf_in;
   logic [PW-1:0]  idx_ff, idx_in;
   logic           have_prev_ff, have_prev_in;
   logic [VB-1:0]  prev_val_ff, prev_val_in;
   logic [CW-1:0]  prev_cnt_ff, prev_cnt_in;
   logic [PW-1:0]  beg_ff, beg_in;
   logic [LW-1:0]  extra_ff, extra_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [KW-1:0]  gone_ff, gone_in;
   logic [KW-1:0]  e_ff, e_in;
   logic           partial_ff, partial_in;
   logic [LW-1:0]  last_take_ff, last_take_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]  rsp_value_ff, rsp_value_in;
   logic [CW-1:0]  rsp_length_ff, rsp_length_in;
   logic [CW-1:0]  rsp_offset_ff, rsp_offset_in;
   logic           rsp_no_bump_ff, rsp_no_bump_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_be_ff, rsp_be_in;
   logic           rsp_ovf_ff, rsp_ovf_in;
   logic [CW-1:0]  rsp_row_ff, rsp_row_in;

   // helpers
   rrbi_pkg::alu_in_type  alu_i;
   rrbi_pkg::alu_out_type alu_o;
   logic          out_free;
   logic [CW-1:0] row_sat;
   logic [PW-1:0] ptr_p1, ptr_m1, used_m1, idx_m1, idx_p1, beg_gone, dst;
   logic [LW-1:0] taken;
   logic          is_full, is_last;
   logic [CW-1:0] emit_len;

   rrbi_alu u_alu (
      .alu_i (alu_i),
      .alu_o (alu_o)
   );

   assign ptr_p1   = ptr_ff + PW'(1);
   assign ptr_m1   = ptr_ff - PW'(1);
   assign used_m1  = used_ff - PW'(1);
   assign idx_m1   = idx_ff - PW'(1);
   assign idx_p1   = idx_ff + PW'(1);
   assign beg_gone = beg_ff + PW'(gone_ff);
   assign dst      = ptr_ff - PW'(gone_ff);
   assign taken    = n_ff - extra_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign row_sat  = (|tot_ff[TOT_W-1:CW]) ? rrbi_pkg::CNT_MAX : tot_ff[CW-1:0];
   assign is_full  = (e_ff < gone_ff);
   assign is_last  = (e_ff == k_ff - KW'(1));
   assign emit_len = is_full ? rd_cnt_ff : CW'(last_take_ff);
   assign rd_addr  = ptr_in[IW-1:0];

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      tot_in       = tot_ff;
      batch_in     = batch_ff;
      ptr_in       = ptr_ff;
      v_in         = v_ff;
      n_in         = n_ff;
      be_in        = be_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      have_prev_in = have_prev_ff;
      prev_val_in  = prev_val_ff;
      prev_cnt_in  = prev_cnt_ff;
      beg_in       = beg_ff;
      extra_in     = extra_ff;
      k_in         = k_ff;
      gone_in      = gone_ff;
      e_in         = e_ff;
      partial_in   = partial_ff;
      last_take_in = last_take_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_no_bump_in = rsp_no_bump_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_be_in      = rsp_be_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_row_in     = rsp_row_ff;

      wr_en   = 1'b0;
      wr_addr = ptr_ff[IW-1:0];
      wr_val  = rd_val_ff;
      wr_cnt  = rd_cnt_ff;
      alu_i.a = '0;
      alu_i.b = '0;

      case (state_ff)
         S_IDLE: begin
            ptr_in = '0;
            if (req_valid) begin
               v_in         = VB'(req_run_value);
               n_in         = req_run_length;
               be_in        = req_batch_end;
               extra_in     = req_run_length;
               ovf_in       = 1'b0;
               have_prev_in = 1'b0;
               k_in         = '0;
               gone_in      = '0;
               e_in         = '0;
               partial_in   = 1'b0;
               idx_in       = '0;
               if (req_run_length == '0) begin
                  state_in = S_OUT;
               end else if (used_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         // find the first run above the new value
         S_SCAN: begin
            alu_i.a = CW'(v_ff);
            alu_i.b = CW'(rd_val_ff);
            if (!alu_o.ge) begin
               idx_in   = ptr_ff;
               state_in = S_PLACE;
            end else begin
               prev_val_in  = rd_val_ff;
               prev_cnt_in  = rd_cnt_ff;
               have_prev_in = 1'b1;
               if (ptr_ff == used_m1) begin
                  idx_in   = used_ff;
                  state_in = S_PLACE;
               end else begin
                  ptr_in = ptr_p1;
               end
            end
         end

         S_PLACE: begin
            if (have_prev_ff && (prev_val_ff == v_ff)) begin
               // merge into the equal left neighbor
               alu_i.a  = prev_cnt_ff;
               alu_i.b  = CW'(n_ff);
               wr_en    = 1'b1;
               wr_addr  = idx_m1[IW-1:0];
               wr_val   = v_ff;
               wr_cnt   = alu_o.sum;
               tot_in   = tot_ff + TOT_W'(alu_o.sum) - TOT_W'(prev_cnt_ff);
               beg_in   = idx_ff;
               ptr_in   = idx_ff;
               state_in = S_MEAS;
            end else if (used_ff == PW'(MAX_RUNS)) begin
               ovf_in   = 1'b1;
               state_in = S_OUT;
            end else if (idx_ff < used_ff) begin
               ptr_in   = used_m1;
               state_in = S_SHR;
            end else begin
               state_in = S_INS;
            end
         end

         // open a slot at idx, last run first
         S_SHR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_p1[IW-1:0];
            if (ptr_ff == idx_ff) begin
               state_in = S_INS;
            end else begin
               ptr_in = ptr_m1;
            end
         end

         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IW-1:0];
            wr_val   = v_ff;
            wr_cnt   = CW'(n_ff);
            used_in  = used_ff + PW'(1);
            tot_in   = tot_ff + TOT_W'(n_ff);
            beg_in   = idx_p1;
            ptr_in   = idx_p1;
            state_in = S_MEAS;
         end

         // count what gets bumped so row_cells is known before the first transfer
         S_MEAS: begin
            alu_i.a = CW'(extra_ff);
            alu_i.b = rd_cnt_ff;
            if ((extra_ff == '0) || (ptr_ff >= used_ff) ||
                (k_ff == KW'(rrbi_pkg::MAX_OUT))) begin
               tot_in = tot_ff - TOT_W'(taken);
               if (k_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  e_in     = '0;
                  ptr_in   = beg_ff;
                  state_in = S_EMIT;
               end
            end else begin
               k_in   = k_ff + KW'(1);
               ptr_in = ptr_p1;
               if (alu_o.ge) begin
                  gone_in  = gone_ff + KW'(1);
                  extra_in = alu_o.diff[LW-1:0];
               end else begin
                  partial_in   = 1'b1;
                  last_take_in = extra_ff;
                  extra_in     = '0;
               end
            end
         end

         S_EMIT: begin
            alu_i.a = batch_ff;
            alu_i.b = emit_len;
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = OW'(rd_val_ff);
               rsp_length_in  = emit_len;
               rsp_offset_in  = batch_ff;
               rsp_no_bump_in = 1'b0;
               rsp_last_in    = is_last;
               rsp_be_in      = is_last && be_ff;
               rsp_ovf_in     = 1'b0;
               rsp_row_in     = row_sat;
               batch_in       = (is_last && be_ff) ? '0 : alu_o.sum;
               e_in           = e_ff + KW'(1);
               ptr_in         = ptr_p1;
               if (is_last) begin
                  ptr_in   = beg_gone;
                  state_in = S_COMP;
               end
            end
         end

         // close the gap left by bumped runs, trimming the partly bumped one
         S_COMP: begin
            alu_i.a = rd_cnt_ff;
            alu_i.b = CW'(last_take_ff);
            if (ptr_ff >= used_ff) begin
               used_in  = used_ff - PW'(gone_ff);
               state_in = S_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = dst[IW-1:0];
               if (partial_ff && (ptr_ff == beg_gone)) begin
                  wr_cnt = alu_o.diff;
               end
               if ((ptr_ff == used_m1) || (gone_ff == '0)) begin
                  used_in  = used_ff - PW'(gone_ff);
                  state_in = S_IDLE;
               end else begin
                  ptr_in = ptr_p1;
               end
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = '0;
               rsp_length_in  = '0;
               rsp_offset_in  = '0;
               rsp_no_bump_in = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_be_in      = be_ff;
               rsp_ovf_in     = ovf_ff;
               rsp_row_in     = row_sat;
               if (be_ff) begin
                  batch_in = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[wr_addr] <= wr_val;
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_val_ff <= val_mem[rd_addr];
      rd_cnt_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         tot_ff       <= '0;
         batch_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tot_ff       <= tot_in;
         batch_ff     <= batch_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      n_ff           <= n_in;
      be_ff          <= be_in;
      ovf_ff         <= ovf_in;
      idx_ff         <= idx_in;
      have_prev_ff   <= have_prev_in;
      prev_val_ff    <= prev_val_in;
      prev_cnt_ff    <= prev_cnt_in;
      beg_ff         <= beg_in;
      extra_ff       <= extra_in;
      k_ff           <= k_in;
      gone_ff        <= gone_in;
      e_ff           <= e_in;
      partial_ff     <= partial_in;
      last_take_ff   <= last_take_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_no_bump_ff <= rsp_no_bump_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_be_ff      <= rsp_be_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_row_ff     <= rsp_row_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bump_value    = rsp_value_ff;
   assign rsp_bump_length   = rsp_length_ff;
   assign rsp_bump_offset   = rsp_offset_ff;
   assign rsp_no_bump       = rsp_no_bump_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_batch_end_out = rsp_be_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_row_cells     = rsp_row_ff;

`ifndef ASSERT_OFF
   // stored runs never exceed the row capacity
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PW'(MAX_RUNS))
      else $error("run count beyond capacity");

   // an empty row holds no cells
   a_empty_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && used_ff == '0) |-> (tot_ff == '0))
      else $error("cell total out of step with stored runs");

   // right shift stays between the insert point and the row end
   a_shift_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHR) |-> (ptr_ff >= idx_ff && ptr_ff < used_ff))
      else $error("shift pointer outside the row");

   // emit never runs past the measured results
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (e_ff < k_ff && gone_ff <= k_ff))
      else $error("emit count beyond measured results");
`endif

endmodule

// ----- rtl/rrbi_alu.sv -----
// shared count unit: saturating add, subtract and unsigned compare
module rrbi_alu (
   input  rrbi_pkg::alu_in_type  alu_i,
   output rrbi_pkg::alu_out_type alu_o
);

   logic [rrbi_pkg::CNT_W:0] wide_sum;

   always_comb begin
      wide_sum  = {1'b0, alu_i.a} + {1'b0, alu_i.b};
      alu_o.sum = wide_sum[rrbi_pkg::CNT_W] ? rrbi_pkg::CNT_MAX
                                            : wide_sum[rrbi_pkg::CNT_W-1:0];
      alu_o.diff = alu_i.a - alu_i.b;
      alu_o.ge   = (alu_i.a >= alu_i.b);
   end

endmodule
